### hw/rtl/lclip_pkg.sv
// shared constants and types for the line clipper
`default_nettype none
package lclip_pkg;
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_TOP    = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;
endpackage
`default_nettype wire

### hw/rtl/line_clip_parametric.sv
// line clipper top level: setup stage, chain of division cells, select and interpolation
// registers in order: setup register, FRAC_BITS division cells, select,
// product and output registers; throughput one segment per cycle unless stalled
// each division cell forms one quotient bit of all four boundary ratios and passes
// the segment on; the whole chain holds while a result waits in a stalled output
// reset clears valid bits and loads the window registers with 0, 0, 639, 479
`default_nettype none
module line_clip_parametric import lclip_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [COORD_BITS-1:0]        cfg_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              visible,
  output logic signed [COORD_BITS-1:0]      clip_start_x,
  output logic signed [COORD_BITS-1:0]      clip_start_y,
  output logic signed [COORD_BITS-1:0]      clip_end_x,
  output logic signed [COORD_BITS-1:0]      clip_end_y
);
  localparam int CW = COORD_BITS;
  localparam int FW = FRAC_BITS;
  localparam int MW = CW + 1;          // magnitude of a difference
  localparam int UW = FW + 1;          // u in [0, 1]
  localparam int N  = FW;              // division cells

  logic signed [CW-1:0] win_left, win_top, win_right, win_bottom;
  // the chain moves only when the output register can take a result
  logic adv;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_top    <= '0;
      win_right  <= CW'(639);
      win_bottom <= CW'(479);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEFT:   win_left   <= cfg_data;
        REG_TOP:    win_top    <= cfg_data;
        REG_RIGHT:  win_right  <= cfg_data;
        REG_BOTTOM: win_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // setup: p/q pairs, signs, early rejection and unity ratios
  logic signed [MW:0] dx, dy;
  logic signed [MW:0] p [4];
  logic signed [MW:0] q [4];
  always_comb begin
    dx = (MW+1)'(end_x) - (MW+1)'(start_x);
    dy = (MW+1)'(end_y) - (MW+1)'(start_y);
    p[0] = -dx; q[0] = (MW+1)'(start_x) - (MW+1)'(win_left);
    p[1] =  dx; q[1] = (MW+1)'(win_right) - (MW+1)'(start_x);
    p[2] = -dy; q[2] = (MW+1)'(start_y) - (MW+1)'(win_top);
    p[3] =  dy; q[3] = (MW+1)'(win_bottom) - (MW+1)'(start_y);
  end

  // per boundary: use (p != 0 and ratio in [0,1)), entry/exit, rejection, one
  logic [3:0] s_use, s_ent, s_one;
  logic       s_rej;
  logic [4*MW-1:0]     s_ap;
  logic [4*(MW+1)-1:0] s_rem;
  always_comb begin
    s_rej = 1'b0;
    for (int k = 0; k < 4; k++) begin
      logic [MW-1:0] ap, aq;
      logic negr;
      ap = MW'(p[k] < 0 ? -p[k] : p[k]);
      aq = MW'(q[k] < 0 ? -q[k] : q[k]);
      negr = (q[k] != 0) && ((q[k] < 0) != (p[k] < 0));
      s_ent[k] = p[k] < 0;
      s_use[k] = 1'b0;
      s_one[k] = 1'b0;
      if (p[k] == 0) begin
        if (q[k] < 0) s_rej = 1'b1;
      end else if (negr) begin
        if (p[k] > 0) s_rej = 1'b1;
      end else if (aq > ap) begin
        if (p[k] < 0) s_rej = 1'b1;
      end else if (aq == ap) begin
        s_one[k] = 1'b1;
      end else begin
        s_use[k] = 1'b1;
      end
      s_ap[k*MW +: MW] = ap;
      s_rem[k*(MW+1) +: MW+1] = {1'b0, aq};
    end
  end

  // stage 0 register
  logic                v0;
  logic [4*MW-1:0]     ap0;
  logic [4*(MW+1)-1:0] rem0;
  logic [12:0]         flags0;   // use, ent, one, rej
  logic [4*CW-1:0]     crd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
    if (adv) begin
      ap0    <= s_ap;
      rem0   <= s_rem;
      flags0 <= {s_use, s_ent, s_one, s_rej};
      crd0   <= {start_x, start_y, end_x, end_y};
    end
  end

  // chain of division cells, one quotient bit each; flags ride along
  logic [N:0]                v_c;
  logic [4*MW-1:0]           ap_c   [N+1];
  logic [4*(MW+1)-1:0]       rem_c  [N+1];
  logic [4*FW-1:0]           quo_c  [N+1];
  logic [12:0]               keep_c [N+1];
  logic [4*CW-1:0]           crd_c  [N+1];

  assign v_c[0]    = v0;
  assign ap_c[0]   = ap0;
  assign rem_c[0]  = rem0;
  assign quo_c[0]  = '0;
  assign keep_c[0] = flags0;
  assign crd_c[0]  = crd0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    lclip_div_cell #(.MW(MW), .FW(FW), .CW(CW)) u_cell (
      .clk(clk), .rst(rst), .en(adv), .v_in(v_c[i]),
      .ap_in(ap_c[i]), .rem_in(rem_c[i]), .quo_in(quo_c[i]),
      .keep_in(keep_c[i]), .coord_in(crd_c[i]),
      .v_out(v_c[i+1]), .ap_out(ap_c[i+1]), .rem_out(rem_c[i+1]),
      .quo_out(quo_c[i+1]), .keep_out(keep_c[i+1]), .coord_out(crd_c[i+1])
    );
  end

  // select stage: narrow u1 from 0 and u2 from 1
  logic [UW-1:0] u1, u2;
  logic          srej;
  always_comb begin
    u1 = '0;
    u2 = UW'(1) << FW;
    srej = keep_c[N][0];
    for (int k = 0; k < 4; k++) begin
      logic [UW-1:0] r;
      r = keep_c[N][1+k] ? (UW'(1) << FW) : {1'b0, quo_c[N][k*FW +: FW]};
      if (keep_c[N][9+k] || keep_c[N][1+k]) begin
        if (keep_c[N][5+k]) begin
          if (r > u1) u1 = r;
        end else begin
          if (r < u2) u2 = r;
        end
      end
    end
  end

  logic                 v1, vis1;
  logic [UW-1:0]        u1r, u2r;
  logic signed [CW-1:0] sx1, sy1;
  logic signed [MW-1:0] dx1, dy1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v_c[N];
    end
    if (adv) begin
      vis1 <= !srej && (u1 <= u2);
      u1r  <= u1;
      u2r  <= u2;
      sx1  <= crd_c[N][4*CW-1 -: CW];
      sy1  <= crd_c[N][3*CW-1 -: CW];
      dx1  <= MW'(signed'(crd_c[N][2*CW-1 -: CW])) - MW'(signed'(crd_c[N][4*CW-1 -: CW]));
      dy1  <= MW'(signed'(crd_c[N][CW-1 -: CW])) - MW'(signed'(crd_c[N][3*CW-1 -: CW]));
    end
  end

  // product stage: magnitude times u, registered
  localparam int PW = MW + UW;
  logic            v2, vis2;
  logic [PW-1:0]   m_sx, m_sy, m_ex, m_ey;
  logic            nx, ny;
  logic signed [CW-1:0] sx2, sy2;
  logic [MW-1:0] adx, ady;
  assign adx = dx1[MW-1] ? MW'(-dx1) : MW'(dx1);
  assign ady = dy1[MW-1] ? MW'(-dy1) : MW'(dy1);
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      vis2 <= vis1;
      m_sx <= PW'(adx) * PW'(u1r);
      m_sy <= PW'(ady) * PW'(u1r);
      m_ex <= PW'(adx) * PW'(u2r);
      m_ey <= PW'(ady) * PW'(u2r);
      nx   <= dx1[MW-1];
      ny   <= dy1[MW-1];
      sx2  <= sx1;
      sy2  <= sy1;
    end
  end

  function automatic logic [CW-1:0] fin(input logic [CW-1:0] s, input logic [PW-1:0] m,
                                        input logic neg);
    logic [CW-1:0] t;
    t = CW'(m >> FW);
    return neg ? s - t : s + t;
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
    if (adv) begin
      visible      <= vis2;
      clip_start_x <= vis2 ? fin(sx2, m_sx, nx) : '0;
      clip_start_y <= vis2 ? fin(sy2, m_sy, ny) : '0;
      clip_end_x   <= vis2 ? fin(sx2, m_ex, nx) : '0;
      clip_end_y   <= vis2 ? fin(sy2, m_ey, ny) : '0;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/lclip_div_cell.sv
// one restoring division step for the four boundary ratios, registered
`default_nettype none
module lclip_div_cell import lclip_pkg::*; #(
  parameter int MW = 17,
  parameter int FW = 16,
  parameter int CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 v_in,
  input  wire logic [4*MW-1:0]      ap_in,
  input  wire logic [4*(MW+1)-1:0]  rem_in,
  input  wire logic [4*FW-1:0]      quo_in,
  input  wire logic [12:0]          keep_in,
  input  wire logic [4*CW-1:0]      coord_in,
  output logic                      v_out,
  output logic [4*MW-1:0]           ap_out,
  output logic [4*(MW+1)-1:0]       rem_out,
  output logic [4*FW-1:0]           quo_out,
  output logic [12:0]               keep_out,
  output logic [4*CW-1:0]           coord_out
);
  logic [4*(MW+1)-1:0] rem_next;
  logic [4*FW-1:0]     quo_next;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [MW+1:0] sh;
      logic [MW+1:0] dv;
      sh = {rem_in[k*(MW+1) +: MW+1], 1'b0};
      dv = {2'b00, ap_in[k*MW +: MW]};
      if (sh >= dv) begin
        rem_next[k*(MW+1) +: MW+1] = (MW+1)'(sh - dv);
        quo_next[k*FW +: FW] = {quo_in[k*FW +: FW-1], 1'b1};
      end else begin
        rem_next[k*(MW+1) +: MW+1] = sh[MW:0];
        quo_next[k*FW +: FW] = {quo_in[k*FW +: FW-1], 1'b0};
      end
    end
  end

  // everything holds while en is low
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      ap_out    <= ap_in;
      rem_out   <= rem_next;
      quo_out   <= quo_next;
      keep_out  <= keep_in;
      coord_out <= coord_in;
    end
  end
endmodule
`default_nettype wire

### dv/line_clip_parametric_tb.sv
// testbench for the line clipper: random and directed segments checked against a local predictor
`default_nettype none
module line_clip_parametric_tb import lclip_pkg::*; ();

  localparam int CB = 16;
  localparam int FB = 16;
  localparam int LATENCY = FB + 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [FB:0] U_ONE = (FB+1)'(1) << FB;

  typedef struct packed {
    logic signed [CB-1:0] sx, sy, ex, ey;
  } segment_t;

  typedef struct packed {
    logic                 vis;
    logic signed [CB-1:0] csx, csy, cex, cey;
  } clip_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_LEFT;
  logic [CB-1:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic visible;
  logic signed [CB-1:0] clip_start_x, clip_start_y, clip_end_x, clip_end_y;

  line_clip_parametric #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .visible(visible),
    .clip_start_x(clip_start_x), .clip_start_y(clip_start_y),
    .clip_end_x(clip_end_x), .clip_end_y(clip_end_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the window
  logic signed [CB-1:0] win_l = '0, win_t = '0, win_r = CB'(639), win_b = CB'(479);

  segment_t segs_pending[$];
  clip_t    clips_expected[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       calm = 1'b0;        // no idling in the last part
  bit       hold_recv = 1'b0;   // request for a long receiver hold-off

  // one boundary: p nonzero, narrows entry/exit in FB fraction bits
  function automatic void narrow(input longint p, input longint q,
                                 inout logic [FB:0] u1, inout logic [FB:0] u2,
                                 inout bit rej);
    longint ap, aq, rem;
    logic [FB:0] quo;
    ap = p < 0 ? -p : p;
    aq = q < 0 ? -q : q;
    quo = '0;
    if (q != 0 && ((q < 0) != (p < 0))) begin
      if (p > 0) rej = 1'b1;
      return;
    end
    if (aq > ap) begin
      if (p < 0) rej = 1'b1;
      return;
    end
    if (aq == ap) quo = U_ONE;
    else begin
      rem = aq;
      for (int i = 0; i < FB; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= ap) begin
          rem -= ap;
          quo[0] = 1'b1;
        end
      end
    end
    if (p < 0) begin
      if (quo > u1) u1 = quo;
    end else if (quo < u2) u2 = quo;
  endfunction

  // start plus u*d truncated toward zero
  function automatic logic signed [CB-1:0] lerp(input longint s, input longint d,
                                                input logic [FB:0] u);
    longint m;
    m = ((d < 0 ? -d : d) * longint'(u)) >>> FB;
    return CB'(s + (d < 0 ? -m : m));
  endfunction

  function automatic clip_t clip_segment(input segment_t sg);
    longint x1, y1, dx, dy;
    longint p[4], q[4];
    logic [FB:0] u1, u2;
    bit rej;
    clip_t r;
    x1 = sg.sx; y1 = sg.sy;
    dx = longint'(sg.ex) - x1;
    dy = longint'(sg.ey) - y1;
    p[0] = -dx; q[0] = x1 - win_l;
    p[1] = dx;  q[1] = longint'(win_r) - x1;
    p[2] = -dy; q[2] = y1 - win_t;
    p[3] = dy;  q[3] = longint'(win_b) - y1;
    u1 = '0; u2 = U_ONE; rej = 1'b0;
    for (int k = 0; k < 4; k++)
      if (p[k] == 0 && q[k] < 0) rej = 1'b1;
    if (!rej)
      for (int k = 0; k < 4; k++)
        if (p[k] != 0) narrow(p[k], q[k], u1, u2, rej);
    r = '0;
    if (!(rej || u1 > u2)) begin
      r.vis = 1'b1;
      r.csx = lerp(x1, dx, u1);
      r.csy = lerp(y1, dy, u1);
      r.cex = lerp(x1, dx, u2);
      r.cey = lerp(y1, dy, u2);
    end
    return r;
  endfunction

  // input transfers, taken at the rising edge
  bit in_took = 1'b0;
  always @(posedge clk) begin
    in_took <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      clips_expected.push_back(clip_segment({start_x, start_y, end_x, end_y}));
      void'(segs_pending.pop_front());
    end
  end

  // driver: one segment per transfer, bursts of idle
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 14) - 1;
        in_valid <= 1'b0;
      end else if (segs_pending.size() > 0) begin
        in_valid <= 1'b1;
        {start_x, start_y, end_x, end_y} <= segs_pending[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, random bursts or a long hold-off
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_recv && !hold_done && hold_left == 0) hold_left = 200;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_done = 1'b1;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(1, 14) - 1;
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // monitor: compare each result transfer to the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (clips_expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer vis=%0d", visible);
      end else begin
        clip_t e;
        e = clips_expected.pop_front();
        if ({visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y} !== e) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %0d (%0d,%0d)-(%0d,%0d) got %0d (%0d,%0d)-(%0d,%0d)",
                     e.vis, e.csx, e.csy, e.cex, e.cey, visible,
                     clip_start_x, clip_start_y, clip_end_x, clip_end_y);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_left > 0
        || (segs_pending.size() == 0 && clips_expected.size() == 0))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [CB-1:0] rand_coord(input int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($urandom_range(0, 700) - 30);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return CB'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  task automatic drain();
    wait (segs_pending.size() == 0 && !in_valid && clips_expected.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic signed [CB-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LEFT:  win_l = val;
      REG_TOP:   win_t = val;
      REG_RIGHT: win_r = val;
      default:   win_b = val;
    endcase
  endtask

  task automatic set_window(input logic signed [CB-1:0] l, t, r, b);
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
  endtask

  task automatic random_segments(input int n, input int mode);
    segment_t sg;
    for (int i = 0; i < n; i++) begin
      sg.sx = rand_coord(mode);
      sg.sy = rand_coord(mode);
      if ($urandom_range(0, 15) == 0) begin
        sg.ex = sg.sx; sg.ey = sg.sy;
      end else if ($urandom_range(0, 7) == 0) begin
        sg.ex = sg.sx; sg.ey = rand_coord(mode);
      end else begin
        sg.ex = rand_coord(mode); sg.ey = rand_coord(mode);
      end
      segs_pending.push_back(sg);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset window, inside, crossing, outside, degenerate, extremes
    segs_pending.push_back({16'sd10, 16'sd10, 16'sd100, 16'sd200});
    segs_pending.push_back({-16'sd100, 16'sd240, 16'sd800, 16'sd240});
    segs_pending.push_back({16'sd320, -16'sd50, 16'sd320, 16'sd600});
    segs_pending.push_back({-16'sd10, -16'sd10, -16'sd20, 16'sd300});
    segs_pending.push_back({16'sd50, 16'sd50, 16'sd50, 16'sd50});
    segs_pending.push_back({-16'sd5, 16'sd50, -16'sd5, 16'sd50});
    segs_pending.push_back({16'sd0, 16'sd0, 16'sd639, 16'sd479});
    segs_pending.push_back({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
    segs_pending.push_back({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
    segs_pending.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    segs_pending.push_back({-16'sd100, 16'sd0, 16'sd0, -16'sd100});
    segs_pending.push_back({16'sd700, 16'sd100, 16'sd600, 16'sd600});
    segs_pending.push_back({16'sd1, 16'sd2, 16'sd638, 16'sd478});
    segs_pending.push_back({16'sd639, 16'sd479, 16'sd0, 16'sd0});
    drain();

    // inverted window and full-range window
    set_window(16'sd100, 16'sd100, -16'sd100, -16'sd100);
    segs_pending.push_back({-16'sd200, 16'sd0, 16'sd200, 16'sd0});
    segs_pending.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0});
    drain();
    set_window(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    segs_pending.push_back({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
    random_segments(80, 0);
    drain();
    set_window(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    random_segments(20, 2);
    drain();

    // long receiver hold-off while segments keep coming
    set_window(-16'sd30, -16'sd20, 16'sd500, 16'sd400);
    hold_recv = 1'b1;
    random_segments(60, 1);
    wait (hold_done);
    hold_recv = 1'b0;
    drain();

    // a few random windows with mixed segments
    for (int w = 0; w < 4; w++) begin
      set_window(CB'($urandom_range(0, 400) - 200), CB'($urandom_range(0, 400) - 200),
                 CB'($urandom_range(0, 800)), CB'($urandom_range(0, 800)));
      random_segments(60, 3);
      random_segments(30, 1);
      random_segments(20, 0);
      drain();
    end

    // last part without idling
    calm = 1'b1;
    set_window(16'sd0, 16'sd0, 16'sd639, 16'sd479);
    random_segments(60, 1);
    drain();

    if (errors == 0 && clips_expected.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
